### rtl/format_string_char_emitter_core_macros.svh
// assertion helpers used by fsce_dp.sv
`ifndef FORMAT_STRING_CHAR_EMITTER_CORE_MACROS_SVH
`define FORMAT_STRING_CHAR_EMITTER_CORE_MACROS_SVH

`ifndef ASSERT_OFF
`define FSCE_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`define FSCE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define FSCE_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg)
`define FSCE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

### rtl/fsce_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package fsce_pkg;

    localparam int WORD_WIDTH_DEF = 32;
    localparam int DIGIT_DEPTH    = 10;
    localparam int DIGIT_IDX_W    = 4;
    localparam int COUNT_W        = 31;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // fixed argument width on the input channel
    localparam int ARG_W = 32;
    // reciprocal of ten for a 32-bit dividend, quotient is product >> 35
    localparam logic [31:0] RECIP_TEN = 32'hCCCC_CCCD;
    localparam int RECIP_SHIFT = 35;

    localparam logic [2:0] CMD_FMT   = 3'd0;
    localparam logic [2:0] CMD_INT   = 3'd1;
    localparam logic [2:0] CMD_STRB  = 3'd2;
    localparam logic [2:0] CMD_NULL  = 3'd3;
    localparam logic [2:0] CMD_EMPTY = 3'd4;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_S       = 8'h73;
    localparam logic [7:0] CH_D       = 8'h64;
    localparam logic [7:0] CH_X       = 8'h78;
    localparam logic [7:0] CH_MINUS   = 8'h2d;
    localparam logic [7:0] CH_NUL     = 8'h00;

    localparam logic [2:0] NULL_LAST_IDX = 3'd5;

    typedef enum logic [1:0] {
        ARG_NONE,
        ARG_STR,
        ARG_DEC,
        ARG_HEX
    } arg_t;

    typedef enum logic [1:0] {
        SEL_CH,
        SEL_MINUS,
        SEL_NULL,
        SEL_DIGIT
    } char_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_EMIT_CHAR,
        ST_EMIT_NULL,
        ST_EMIT_MINUS,
        ST_DEC_MUL,
        ST_DEC_STORE,
        ST_HEX_STORE,
        ST_EMIT_DIGIT
    } state_t;

    typedef struct packed {
        logic      capture;
        logic      load_work;
        logic      negate;
        logic      mul;
        logic      store_dec;
        logic      store_hex;
        logic      emit;
        char_sel_t sel;
        logic      last;
    } dp_cmd_t;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] ch;
        logic       fin;
        logic       sign;
        logic       work_zero;
        logic       k_nz;
        logic       k_one;
        logic       k_full;
        logic       null_last;
        logic       out_free;
    } dp_stat_t;

    function automatic logic [7:0] hex_glyph(input logic [3:0] d);
        logic [7:0] c;
        c = (d < 4'd10) ? (8'h30 + {4'd0, d}) : (8'h57 + {4'd0, d});
        return c;
    endfunction

    function automatic logic [7:0] null_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h28;
            3'd1:    c = 8'h6e;
            3'd2:    c = 8'h75;
            3'd3:    c = 8'h6c;
            3'd4:    c = 8'h6c;
            3'd5:    c = 8'h29;
            default: c = 8'h29;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

### rtl/fsce_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module fsce_ctrl
    import fsce_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd
);

    state_t state_reg, state_next;
    arg_t   await_reg, await_next;
    logic   pct_reg, pct_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            await_reg <= ARG_NONE;
            pct_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            await_reg <= await_next;
            pct_reg   <= pct_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        await_next = await_reg;
        pct_next   = pct_reg;
        cmd        = '0;
        cmd.sel    = SEL_CH;
        in_ready   = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end

            ST_DECODE: begin
                state_next = ST_IDLE;
                case (stat.cmd)
                    CMD_FMT: begin
                        await_next = ARG_NONE;
                        if (pct_reg) begin
                            pct_next = 1'b0;
                            if (stat.ch == CH_S) begin
                                await_next = ARG_STR;
                            end else if (stat.ch == CH_D) begin
                                await_next = ARG_DEC;
                            end else if (stat.ch == CH_X) begin
                                await_next = ARG_HEX;
                            end else begin
                                state_next = ST_EMIT_CHAR;
                            end
                        end else if (stat.ch == CH_PERCENT && !stat.fin) begin
                            pct_next = 1'b1;
                        end else begin
                            state_next = ST_EMIT_CHAR;
                        end
                    end
                    CMD_INT: begin
                        if (await_reg == ARG_DEC) begin
                            cmd.load_work = 1'b1;
                            cmd.negate    = stat.sign;
                            await_next    = ARG_NONE;
                            state_next    = stat.sign ? ST_EMIT_MINUS : ST_DEC_MUL;
                        end else if (await_reg == ARG_HEX) begin
                            cmd.load_work = 1'b1;
                            await_next    = ARG_NONE;
                            state_next    = ST_HEX_STORE;
                        end
                    end
                    CMD_STRB: begin
                        if (await_reg == ARG_STR) begin
                            if (stat.ch == CH_NUL) begin
                                await_next = ARG_NONE;
                            end else begin
                                state_next = ST_EMIT_CHAR;
                                if (stat.fin) begin
                                    await_next = ARG_NONE;
                                end
                            end
                        end
                    end
                    CMD_NULL: begin
                        if (await_reg == ARG_STR) begin
                            await_next = ARG_NONE;
                            state_next = ST_EMIT_NULL;
                        end
                    end
                    CMD_EMPTY: begin
                        if (await_reg == ARG_STR) begin
                            await_next = ARG_NONE;
                        end
                    end
                    default: begin
                        state_next = ST_IDLE;
                    end
                endcase
            end

            ST_EMIT_CHAR: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    cmd.sel    = SEL_CH;
                    cmd.last   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            ST_EMIT_NULL: begin
                if (stat.out_free) begin
                    cmd.emit = 1'b1;
                    cmd.sel  = SEL_NULL;
                    cmd.last = stat.null_last;
                    if (stat.null_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_EMIT_MINUS: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    cmd.sel    = SEL_MINUS;
                    state_next = ST_DEC_MUL;
                end
            end

            // at least one digit, then stop on zero quotient or a full buffer
            ST_DEC_MUL: begin
                if (stat.k_nz && (stat.work_zero || stat.k_full)) begin
                    state_next = ST_EMIT_DIGIT;
                end else begin
                    cmd.mul    = 1'b1;
                    state_next = ST_DEC_STORE;
                end
            end

            ST_DEC_STORE: begin
                cmd.store_dec = 1'b1;
                state_next    = ST_DEC_MUL;
            end

            ST_HEX_STORE: begin
                if (stat.k_nz && (stat.work_zero || stat.k_full)) begin
                    state_next = ST_EMIT_DIGIT;
                end else begin
                    cmd.store_hex = 1'b1;
                end
            end

            ST_EMIT_DIGIT: begin
                if (stat.out_free) begin
                    cmd.emit = 1'b1;
                    cmd.sel  = SEL_DIGIT;
                    cmd.last = stat.k_one;
                    if (stat.k_one) begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

### rtl/fsce_dp.sv
`timescale 1ns / 1ps
`default_nettype none
`include "format_string_char_emitter_core_macros.svh"
module fsce_dp
    import fsce_pkg::*;
#(
    parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire dp_cmd_t            cmd,
    output dp_stat_t                stat,
    input  wire logic [2:0]         in_cmd,
    input  wire logic [7:0]         in_ch,
    input  wire logic [ARG_W-1:0]   in_value,
    input  wire logic               in_fin,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [7:0]              out_char,
    output logic                    out_last,
    output logic [COUNT_W-1:0]      out_count
);

    // magnitude never exceeds the argument port width
    localparam int MAG_W = (WORD_WIDTH < ARG_W) ? WORD_WIDTH : ARG_W;
    localparam logic [ARG_W-1:0] MAG_MASK =
        (MAG_W == ARG_W) ? {ARG_W{1'b1}} : ARG_W'((64'd1 << MAG_W) - 64'd1);
    localparam bit SIGN_USED = (WORD_WIDTH <= ARG_W);

    logic [2:0]             cmd_reg;
    logic [7:0]             ch_reg;
    logic [ARG_W-1:0]       value_reg;
    logic                   fin_reg;
    logic [ARG_W-1:0]       work_reg, work_next;
    logic [2*ARG_W-1:0]     prod_reg;
    logic [DIGIT_IDX_W-1:0] k_reg, k_next;
    logic [3:0]             digit_mem [DIGIT_DEPTH];
    logic [3:0]             digit_rd_reg;
    logic [2:0]             nidx_reg, nidx_next;
    logic [COUNT_W-1:0]     count_reg, count_next;
    logic                   m_valid_reg, m_valid_next;
    logic [7:0]             m_char_reg;
    logic                   m_last_reg;
    logic [COUNT_W-1:0]     m_count_reg;

    logic [ARG_W-1:0]       mag;
    logic [ARG_W-1:0]       quot;
    logic [ARG_W-1:0]       ten_q;
    logic [ARG_W-1:0]       rem_full;
    logic [3:0]             new_digit;
    logic [DIGIT_IDX_W-1:0] rd_idx;
    logic [DIGIT_IDX_W-1:0] rd_next_idx;
    logic [7:0]             emit_char;
    logic                   out_free;
    logic                   store;

    assign out_free = !m_valid_reg || out_ready;
    assign mag      = value_reg & MAG_MASK;
    assign quot     = ARG_W'(prod_reg[2*ARG_W-1:RECIP_SHIFT]);
    assign ten_q    = (quot << 3) + (quot << 1);
    assign rem_full = work_reg - ten_q;
    assign store    = cmd.store_dec || cmd.store_hex;
    assign new_digit = cmd.store_dec ? rem_full[3:0] : work_reg[3:0];
    assign rd_idx   = k_reg - DIGIT_IDX_W'(1);
    // top digit for the next cycle; a stop check always lies between the last store and the emit
    assign rd_next_idx = k_next - DIGIT_IDX_W'(1);

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            cmd_reg   <= in_cmd;
            ch_reg    <= in_ch;
            value_reg <= in_value;
            fin_reg   <= in_fin;
        end
        if (cmd.mul) begin
            prod_reg <= (2*ARG_W)'(work_reg) * (2*ARG_W)'(RECIP_TEN);
        end
        if (store) begin
            digit_mem[k_reg] <= new_digit;
        end
        digit_rd_reg <= digit_mem[rd_next_idx];
        work_reg <= work_next;
        nidx_reg <= nidx_next;
        k_reg    <= k_next;
        if (cmd.emit) begin
            m_char_reg  <= emit_char;
            m_last_reg  <= cmd.last;
            m_count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        work_next = work_reg;
        if (cmd.load_work) begin
            work_next = cmd.negate ? ((ARG_W'(0) - mag) & MAG_MASK) : mag;
        end else if (cmd.store_dec) begin
            work_next = quot;
        end else if (cmd.store_hex) begin
            work_next = work_reg >> 4;
        end
    end

    always_comb begin
        k_next = k_reg;
        if (cmd.load_work) begin
            k_next = '0;
        end else if (store) begin
            k_next = k_reg + DIGIT_IDX_W'(1);
        end else if (cmd.emit && cmd.sel == SEL_DIGIT) begin
            k_next = rd_idx;
        end
    end

    always_comb begin
        nidx_next = nidx_reg;
        if (cmd.capture) begin
            nidx_next = '0;
        end else if (cmd.emit && cmd.sel == SEL_NULL) begin
            nidx_next = nidx_reg + 3'd1;
        end
    end

    always_comb begin
        case (cmd.sel)
            SEL_CH:    emit_char = ch_reg;
            SEL_MINUS: emit_char = CH_MINUS;
            SEL_NULL:  emit_char = null_char(nidx_reg);
            SEL_DIGIT: emit_char = hex_glyph(digit_rd_reg);
            default:   emit_char = ch_reg;
        endcase
    end

    always_comb begin
        count_next = count_reg;
        if (cmd.emit && count_reg != COUNT_MAX) begin
            count_next = count_reg + COUNT_W'(1);
        end
        m_valid_next = cmd.emit ? 1'b1 : (out_ready ? 1'b0 : m_valid_reg);
    end

    always_comb begin
        stat.cmd       = cmd_reg;
        stat.ch        = ch_reg;
        stat.fin       = fin_reg;
        stat.sign      = SIGN_USED && value_reg[MAG_W-1];
        stat.work_zero = (work_reg == '0);
        stat.k_nz      = (k_reg != '0);
        stat.k_one     = (k_reg == DIGIT_IDX_W'(1));
        stat.k_full    = (k_reg == DIGIT_IDX_W'(DIGIT_DEPTH));
        stat.null_last = (nidx_reg == NULL_LAST_IDX);
        stat.out_free  = out_free;
    end

    assign out_valid = m_valid_reg;
    assign out_char  = m_char_reg;
    assign out_last  = m_last_reg;
    assign out_count = m_count_reg;

    `FSCE_ASSERT_NOW(a_emit_needs_slot, aclk, aresetn, cmd.emit, out_free,
        "emit into a full output register")
    `FSCE_ASSERT_NOW(a_digit_present, aclk, aresetn, cmd.emit && cmd.sel == SEL_DIGIT,
        k_reg != '0, "digit emitted from an empty buffer")
    `FSCE_ASSERT_NOW(a_store_in_range, aclk, aresetn, store,
        k_reg < DIGIT_IDX_W'(DIGIT_DEPTH), "digit stored past the buffer end")
    `FSCE_ASSERT_NEXT(a_count_sticks, aclk, aresetn, count_reg == COUNT_MAX,
        count_reg == COUNT_MAX, "character count left saturation")
    `FSCE_ASSERT_NEXT(a_emit_shows, aclk, aresetn, cmd.emit,
        m_valid_reg && m_count_reg == count_reg, "emitted character not presented with its count")

endmodule
`default_nettype wire

### rtl/format_string_char_emitter_core.sv
`timescale 1ns / 1ps
`default_nettype none
// one input item at a time; s_tready is high only while the controller is idle
// format byte or string byte that prints: decoded, then its character is registered for output, then idle
// decimal: a divide-by-ten loop, one multiply state plus one store state per digit,
//   hex: one nibble shift per digit; then one character per cycle while m_tready holds
// the worst case per item is set by the divide-by-ten loop
// aresetn (synchronous, active low) clears controller state, character count and m_tvalid
module format_string_char_emitter_core
    import fsce_pkg::*;
#(
    parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // cmd[2:0], ch[10:3], value[42:11], zero fill
    input  wire logic        s_tlast,   // final_req
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // out_char[7:0], chars_so_far[38:8], zero fill
    output logic             m_tlast    // last_of_run
);

    dp_cmd_t            dcmd;
    dp_stat_t           dstat;
    logic [7:0]         out_char;
    logic [COUNT_W-1:0] out_count;

    fsce_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (dstat),
        .cmd      (dcmd)
    );

    fsce_dp #(
        .WORD_WIDTH (WORD_WIDTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (dcmd),
        .stat      (dstat),
        .in_cmd    (s_tdata[2:0]),
        .in_ch     (s_tdata[10:3]),
        .in_value  (s_tdata[42:11]),
        .in_fin    (s_tlast),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_char  (out_char),
        .out_last  (m_tlast),
        .out_count (out_count)
    );

    assign m_tdata = {1'b0, out_count, out_char};

endmodule
`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import fsce_pkg::*;

    localparam int RANDOM_ITEMS  = 95;
    localparam int SETTLE_CYCLES = 40;    // longer than one item's worst latency
    localparam int IDLE_LIMIT    = 2000;

    // commands outside the defined set
    localparam logic [2:0] CMD_RESERVED = 3'd7;

    localparam logic [127:0] GLYPHS    = "0123456789abcdef";
    localparam logic [47:0]  NULL_TEXT = "(null)";

    typedef struct {
        logic [2:0]  cmd;
        logic [7:0]  ch;
        logic [31:0] value;
        logic        fin;
        bit          hold;    // sender waits for the output to drain first
    } fmt_item_t;

    typedef struct {
        logic [7:0]         ch;
        logic               last;
        logic [COUNT_W-1:0] count;
    } char_exp_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tlast;

    format_string_char_emitter_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    fmt_item_t pend_q[$];
    char_exp_t char_q[$];
    fmt_item_t cur_item;

    // formatter state as seen from outside
    bit                 pct_held;
    arg_t               awaiting;
    logic [COUNT_W-1:0] char_total;

    int  errors;
    int  items_taken;
    int  chars_seen;
    int  args_used;
    int  idle_cycles;
    int  drv_gap;
    int  mon_stall;
    int  drain_wait;
    bit  drv_valid;
    bit  mon_ready;
    bit  calm;
    bit  hold_next;
    bit  mid_hold_done;
    int  total_items;
    int  seq_items;
    int  before_n;
    int  kind;
    int  n;
    int  i;
    int  mode;
    logic [7:0]  c;
    logic [31:0] val;

    function automatic int draw_gap();
        if ($urandom_range(0, 15) == 0)
            calm = !calm;
        return calm ? 0 : $urandom_range(0, 16);
    endfunction

    task automatic add_item(input logic [2:0] cmd, input logic [7:0] ch,
                            input logic [31:0] value, input logic fin);
        fmt_item_t it;
        it.cmd   = cmd;
        it.ch    = ch;
        it.value = value;
        it.fin   = fin;
        it.hold  = hold_next;
        hold_next = 1'b0;
        pend_q.push_back(it);
    endtask

    task automatic report_mismatch(input string what);
        $display("mismatch at output character %0d: %s", chars_seen, what);
        errors++;
    endtask

    // works out the characters one accepted transfer produces
    task automatic format_item(input fmt_item_t it);
        logic [7:0]  run_q[$];
        logic [3:0]  digits[10];
        logic [31:0] mag;
        logic [31:0] radix;
        int          k;
        char_exp_t   e;
        case (it.cmd)
            CMD_FMT: begin
                awaiting = ARG_NONE;
                if (pct_held) begin
                    pct_held = 1'b0;
                    if (it.ch == CH_S)
                        awaiting = ARG_STR;
                    else if (it.ch == CH_D)
                        awaiting = ARG_DEC;
                    else if (it.ch == CH_X)
                        awaiting = ARG_HEX;
                    else
                        run_q.push_back(it.ch);
                end else if (it.ch == CH_PERCENT && !it.fin) begin
                    pct_held = 1'b1;
                end else begin
                    run_q.push_back(it.ch);
                end
            end
            CMD_INT: begin
                if (awaiting inside {ARG_DEC, ARG_HEX}) begin
                    mag   = it.value;
                    radix = (awaiting == ARG_DEC) ? 32'd10 : 32'd16;
                    if (awaiting == ARG_DEC && mag[31]) begin
                        run_q.push_back(CH_MINUS);
                        mag = -mag;
                    end
                    k = 0;
                    do begin
                        digits[k] = 4'(mag % radix);
                        mag = mag / radix;
                        k++;
                    end while (mag != 0 && k < 10);
                    while (k > 0) begin
                        k--;
                        run_q.push_back(GLYPHS[8*(15-digits[k]) +: 8]);
                    end
                    awaiting = ARG_NONE;
                    args_used++;
                end
            end
            CMD_STRB: begin
                if (awaiting == ARG_STR) begin
                    if (it.ch == CH_NUL) begin
                        awaiting = ARG_NONE;
                    end else begin
                        run_q.push_back(it.ch);
                        if (it.fin)
                            awaiting = ARG_NONE;
                    end
                    if (awaiting == ARG_NONE)
                        args_used++;
                end
            end
            CMD_NULL: begin
                if (awaiting == ARG_STR) begin
                    for (k = 0; k < 6; k++)
                        run_q.push_back(NULL_TEXT[8*(5-k) +: 8]);
                    awaiting = ARG_NONE;
                    args_used++;
                end
            end
            CMD_EMPTY: begin
                if (awaiting == ARG_STR) begin
                    awaiting = ARG_NONE;
                    args_used++;
                end
            end
            default: begin
            end
        endcase
        for (k = 0; k < run_q.size(); k++) begin
            if (char_total != COUNT_MAX)
                char_total++;
            e.ch    = run_q[k];
            e.last  = (k == run_q.size() - 1);
            e.count = char_total;
            char_q.push_back(e);
        end
    endtask

    // sender
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
            drv_gap = draw_gap();
            drain_wait = 0;
        end else begin
            drv_valid = s_tvalid;
            if (s_tvalid && s_tready) begin
                format_item(cur_item);
                items_taken++;
                drv_valid = 1'b0;
                drv_gap = draw_gap();
            end
            if (!drv_valid && pend_q.size() != 0) begin
                if (pend_q[0].hold && (char_q.size() != 0 || drain_wait < SETTLE_CYCLES)) begin
                    drain_wait = (char_q.size() != 0) ? 0 : drain_wait + 1;
                end else if (drv_gap != 0) begin
                    drv_gap--;
                end else begin
                    cur_item = pend_q.pop_front();
                    drv_valid = 1'b1;
                    drain_wait = 0;
                    s_tdata <= {5'd0, cur_item.value, cur_item.ch, cur_item.cmd};
                    s_tlast <= cur_item.fin;
                end
            end
            s_tvalid <= drv_valid;
        end
    end

    // receiver and checker
    always @(posedge aclk) begin
        char_exp_t e;
        if (!aresetn) begin
            m_tready <= 1'b0;
            mon_stall = 0;
        end else begin
            mon_ready = m_tready;
            if (m_tvalid && m_tready) begin
                if (char_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected character 8'h%02h", m_tdata[7:0]));
                end else begin
                    e = char_q.pop_front();
                    if (m_tdata[7:0] !== e.ch)
                        report_mismatch($sformatf("char 8'h%02h, expected 8'h%02h",
                                                  m_tdata[7:0], e.ch));
                    if (m_tdata[38:8] !== e.count)
                        report_mismatch($sformatf("count %0d, expected %0d",
                                                  m_tdata[38:8], e.count));
                    if (m_tlast !== e.last)
                        report_mismatch($sformatf("tlast %b, expected %b", m_tlast, e.last));
                end
                chars_seen++;
                mon_ready = 1'b0;
                mon_stall = draw_gap();
            end
            if (!mon_ready) begin
                if (mon_stall != 0)
                    mon_stall--;
                else
                    mon_ready = 1'b1;
            end
            m_tready <= mon_ready;
        end
    end

    // watchdog on transfers of either side
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("stalled for %0d cycles, %0d transfers pending", idle_cycles,
                         pend_q.size());
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin
        pct_held   = 1'b0;
        awaiting   = ARG_NONE;
        char_total = '0;

        // plain bytes, zero byte, all-ones byte with tlast
        add_item(CMD_FMT, "H", 32'h0, 1'b0);
        add_item(CMD_FMT, CH_NUL, 32'hFFFF_FFFF, 1'b0);
        add_item(CMD_FMT, 8'hFF, 32'h0, 1'b1);
        // arguments nobody waits for, and a reserved command
        add_item(CMD_INT, 8'h00, 32'h1234_5678, 1'b0);
        add_item(CMD_STRB, "z", 32'h0, 1'b1);
        add_item(CMD_RESERVED, 8'hFF, 32'hFFFF_FFFF, 1'b1);
        // most negative decimal
        add_item(CMD_FMT, CH_PERCENT, 32'h0, 1'b0);
        add_item(CMD_FMT, CH_D, 32'h0, 1'b0);
        add_item(CMD_INT, 8'h00, 32'h8000_0000, 1'b0);
        // widest hex
        add_item(CMD_FMT, CH_PERCENT, 32'h0, 1'b0);
        add_item(CMD_FMT, CH_X, 32'h0, 1'b0);
        add_item(CMD_INT, 8'h00, 32'hFFFF_FFFF, 1'b1);
        // string ended by a zero byte
        add_item(CMD_FMT, CH_PERCENT, 32'h0, 1'b0);
        add_item(CMD_FMT, CH_S, 32'h0, 1'b0);
        add_item(CMD_STRB, "a", 32'h0, 1'b0);
        add_item(CMD_STRB, CH_NUL, 32'h0, 1'b0);
        // null string
        add_item(CMD_FMT, CH_PERCENT, 32'h0, 1'b0);
        add_item(CMD_FMT, CH_S, 32'h0, 1'b0);
        add_item(CMD_NULL, 8'h00, 32'h0, 1'b0);
        // unknown conversion, then a trailing percent
        add_item(CMD_FMT, CH_PERCENT, 32'h0, 1'b0);
        add_item(CMD_FMT, "q", 32'h0, 1'b0);
        add_item(CMD_FMT, CH_PERCENT, 32'h0, 1'b1);
        // wait for a decimal abandoned by a format byte
        add_item(CMD_FMT, CH_PERCENT, 32'h0, 1'b0);
        add_item(CMD_FMT, CH_D, 32'h0, 1'b0);
        add_item(CMD_FMT, "Z", 32'h0, 1'b1);

        hold_next = 1'b1;
        seq_items = 0;
        while (seq_items < RANDOM_ITEMS) begin
            before_n = pend_q.size();
            if (!mid_hold_done && seq_items >= RANDOM_ITEMS / 2) begin
                hold_next = 1'b1;
                mid_hold_done = 1'b1;
            end
            kind = $urandom_range(0, 9);
            case (kind)
                0, 1: begin
                    n = $urandom_range(1, 3);
                    for (i = 0; i < n; i++)
                        add_item(CMD_FMT, 8'($urandom_range(0, 255)), $urandom,
                                 (i == n - 1) ? 1'($urandom_range(0, 1)) : 1'b0);
                end
                2, 3: begin
                    add_item(CMD_FMT, CH_PERCENT, $urandom, 1'b0);
                    add_item(CMD_FMT, $urandom_range(0, 1) ? CH_D : CH_X, $urandom,
                             1'($urandom_range(0, 1)));
                    if ($urandom_range(0, 7) == 0)
                        add_item(CMD_STRB, 8'($urandom_range(1, 255)), $urandom, 1'b0);
                    case ($urandom_range(0, 5))
                        0:       val = 32'h0;
                        1:       val = 32'h8000_0000;
                        2:       val = 32'h7FFF_FFFF;
                        3:       val = 32'hFFFF_FFFF;
                        4:       val = $urandom_range(0, 999);
                        default: val = $urandom;
                    endcase
                    add_item(CMD_INT, 8'($urandom_range(0, 255)), val,
                             1'($urandom_range(0, 1)));
                end
                4, 5: begin
                    add_item(CMD_FMT, CH_PERCENT, $urandom, 1'b0);
                    add_item(CMD_FMT, CH_S, $urandom, 1'($urandom_range(0, 1)));
                    case ($urandom_range(0, 5))
                        0: add_item(CMD_NULL, 8'($urandom_range(0, 255)), $urandom,
                                    1'($urandom_range(0, 1)));
                        1: add_item(CMD_EMPTY, 8'($urandom_range(0, 255)), $urandom,
                                    1'($urandom_range(0, 1)));
                        default: begin
                            n = $urandom_range(1, 4);
                            mode = $urandom_range(0, 2);
                            for (i = 0; i < n; i++)
                                add_item(CMD_STRB, 8'($urandom_range(1, 255)), $urandom,
                                         (i == n - 1 && mode == 0));
                            // otherwise a zero byte or the next format byte ends it
                            if (mode == 1)
                                add_item(CMD_STRB, CH_NUL, $urandom,
                                         1'($urandom_range(0, 1)));
                        end
                    endcase
                end
                6: begin
                    add_item(CMD_FMT, CH_PERCENT, $urandom, 1'b0);
                    do
                        c = 8'($urandom_range(0, 255));
                    while (c inside {CH_S, CH_D, CH_X});
                    add_item(CMD_FMT, c, $urandom, 1'($urandom_range(0, 1)));
                end
                7: add_item(CMD_FMT, CH_PERCENT, $urandom, 1'b1);
                8: begin
                    n = $urandom_range(1, 3);
                    for (i = 0; i < n; i++)
                        add_item(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                                 $urandom, 1'($urandom_range(0, 1)));
                end
                default: begin
                    add_item(CMD_FMT, CH_PERCENT, $urandom, 1'b0);
                    case ($urandom_range(0, 2))
                        0:       c = CH_S;
                        1:       c = CH_D;
                        default: c = CH_X;
                    endcase
                    add_item(CMD_FMT, c, $urandom, 1'b0);
                    add_item(CMD_FMT, 8'($urandom_range(0, 255)), $urandom,
                             1'($urandom_range(0, 1)));
                end
            endcase
            seq_items += pend_q.size() - before_n;
        end
        total_items = pend_q.size();

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        while (items_taken < total_items || char_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("covered %0d input transfers, %0d arguments converted, %0d characters checked",
                 items_taken, args_used, chars_seen);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches", errors);
            $display("FAILURE");
        end
        $finish;
    end

endmodule
